FILE: rtl/core/grid_step_sequencer_playhead_top_macros.svh
// Assertion macros for the grid step sequencer playhead.
// Used by grid_step_sequencer_playhead_top; empty when SYNTHESIS is defined.
`ifndef GRID_STEP_SEQUENCER_PLAYHEAD_TOP_MACROS_SVH
`define GRID_STEP_SEQUENCER_PLAYHEAD_TOP_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define GSP_ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("same-cycle check failed");
// next-cycle implication
`define GSP_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("next-cycle check failed");
`else
`define GSP_ASSERT_IMPLIES(label, clk, rst_n, pre, post)
`define GSP_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

FILE: rtl/core/gsp_pkg.sv
// Types, codes and helper functions for the grid step sequencer playhead.
// No dependencies; imported by gsp_divider, gsp_motion and the top level.
`timescale 1ns / 1ps

package gsp_pkg;

    localparam int COLUMNS = 64;
    localparam int ROWS    = 16;
    localparam int COL_W   = $clog2(COLUMNS);
    localparam int ROW_W   = $clog2(ROWS);
    localparam int LEN_W   = COL_W + 1;
    localparam int CNT_W   = $clog2(ROWS + 1);
    localparam int FRAC_W  = 16;
    localparam int SCALE_W = 10;
    localparam int DIV_W   = COL_W + SCALE_W;
    localparam int DIV_BITS  = 4;
    localparam int DIV_STEPS = DIV_W / DIV_BITS;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam logic [COL_W-1:0]   LAST_COLUMN = COL_W'(COLUMNS - 1);
    localparam logic [LEN_W-1:0]   LEN_MAX     = LEN_W'(COLUMNS);
    localparam logic [SCALE_W-1:0] SCALE_MAX   = '1;

    localparam logic [2:0] OP_CLOCK    = 3'd0;
    localparam logic [2:0] OP_ARM      = 3'd1;
    localparam logic [2:0] OP_CLEAR    = 3'd2;
    localparam logic [2:0] OP_SET_CELL = 3'd3;
    localparam logic [2:0] OP_LOCATE   = 3'd4;

    localparam logic [2:0] MODE_FORWARD      = 3'd0;
    localparam logic [2:0] MODE_BACKWARD     = 3'd1;
    localparam logic [2:0] MODE_PINGPONG     = 3'd2;
    localparam logic [2:0] MODE_PINGPONG_ALT = 3'd3;
    localparam logic [2:0] MODE_RANDOM       = 3'd4;

    typedef enum logic [1:0] {
        CFG_START,
        CFG_LENGTH,
        CFG_MODE,
        CFG_SCALE
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MODIFY,
        ST_FETCH,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [2:0]        op;
        logic [COL_W-1:0]  column;
        logic [ROW_W-1:0]  row;
        logic              cell_value;
        logic [FRAC_W-1:0] random_fraction;
    } item_t;

    typedef struct packed {
        logic [COL_W-1:0]   position;
        logic [ROWS-1:0]    column_gates;
        logic [CNT_W-1:0]   rows_on;
        logic               end_of_cycle;
        logic [SCALE_W-1:0] position_scaled;
    } result_t;

    typedef struct packed {
        logic [COL_W-1:0] start_column;
        logic [LEN_W-1:0] loop_length;
        logic [2:0]       play_mode;
        logic             absolute_scale;
    } cfg_t;

    typedef struct packed {
        logic [COL_W-1:0] lo;
        logic [COL_W-1:0] hi;
        logic [LEN_W-1:0] len;
    } bounds_t;

    typedef struct packed {
        logic [COL_W-1:0] pos;
        logic             eoc;
    } motion_t;

    typedef struct packed {
        logic busy;
        logic last;
    } div_status_t;

    function automatic bounds_t loop_bounds(cfg_t c);
        bounds_t          b;
        logic [LEN_W-1:0] last_sum;
        b.lo = c.start_column;
        if (c.loop_length == '0)
            b.len = LEN_W'(1);
        else if (c.loop_length > LEN_MAX)
            b.len = LEN_MAX;
        else
            b.len = c.loop_length;
        last_sum = {1'b0, b.lo} + b.len - LEN_W'(1);
        b.hi = (last_sum > {1'b0, LAST_COLUMN}) ? LAST_COLUMN : last_sum[COL_W-1:0];
        return b;
    endfunction

    function automatic logic [CNT_W-1:0] count_ones(logic [ROWS-1:0] v);
        logic [2:0]       nib [4];
        logic [CNT_W-1:0] total;
        for (int n = 0; n < 4; n++)
        begin
            nib[n] = 3'(v[4*n]) + 3'(v[4*n+1]) + 3'(v[4*n+2]) + 3'(v[4*n+3]);
        end
        total = CNT_W'(nib[0]) + CNT_W'(nib[1]) + CNT_W'(nib[2]) + CNT_W'(nib[3]);
        return total;
    endfunction

endpackage

FILE: rtl/core/gsp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module gsp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/gsp_divider.sv
// Iterative restoring divider, DIV_BITS quotient bits per cycle.
// Depends on gsp_pkg.
`timescale 1ns / 1ps

module gsp_divider (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [gsp_pkg::DIV_W-1:0] dividend,
    input  logic [gsp_pkg::COL_W-1:0] divisor,
    output gsp_pkg::div_status_t      status,
    output logic [gsp_pkg::DIV_W-1:0] quotient
);
    import gsp_pkg::*;

    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0]  work_reg, work_next;
    logic [COL_W-1:0]  rem_reg, rem_next;
    logic [COL_W-1:0]  divisor_reg, divisor_next;

    logic [DIV_W-1:0]  work_w;
    logic [COL_W-1:0]  rem_w;
    logic [COL_W:0]    trial;
    logic              last_w;

    assign last_w = busy_reg && (cnt_reg == STEP_W'(DIV_STEPS - 1));

    // one batch of compare-subtract steps
    always_comb
    begin
        rem_w  = rem_reg;
        work_w = work_reg;
        trial  = '0;
        for (int i = 0; i < DIV_BITS; i++)
        begin
            trial  = {rem_w, work_w[DIV_W-1]};
            work_w = {work_w[DIV_W-2:0], 1'b0};
            if (trial >= {1'b0, divisor_reg})
            begin
                rem_w     = COL_W'(trial - {1'b0, divisor_reg});
                work_w[0] = 1'b1;
            end
            else
            begin
                rem_w = trial[COL_W-1:0];
            end
        end
    end

    always_comb
    begin
        busy_next    = busy_reg;
        cnt_next     = cnt_reg;
        work_next    = work_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        if (start)
        begin
            busy_next    = 1'b1;
            cnt_next     = '0;
            work_next    = dividend;
            rem_next     = '0;
            divisor_next = divisor;
        end
        else if (busy_reg)
        begin
            work_next = work_w;
            rem_next  = rem_w;
            cnt_next  = cnt_reg + STEP_W'(1);
            if (last_w)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg    <= work_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
    end

    assign status.busy = busy_reg;
    assign status.last = last_w;
    assign quotient    = work_reg;

endmodule

FILE: rtl/core/gsp_motion.sv
// Playhead state and stepping: play modes, arming, locate, end-of-cycle flag.
// Depends on gsp_pkg.
`timescale 1ns / 1ps

module gsp_motion (
    input  logic           clk,
    input  logic           rst_n,
    input  gsp_pkg::cfg_t  cfg,
    input  logic           update,
    input  gsp_pkg::item_t item,
    output gsp_pkg::motion_t motion
);
    import gsp_pkg::*;

    logic [COL_W-1:0] playhead_reg, playhead_next;
    logic             armed_reg, armed_next;
    logic             fwd_reg, fwd_next;
    logic             seen_reg, seen_next;
    logic             eoc_reg, eoc_next;

    bounds_t                 b;
    logic [2:0]              mode;
    logic [LEN_W-1:0]        far_sum;
    logic [FRAC_W+LEN_W-1:0] prod;
    logic [LEN_W-1:0]        off;
    logic signed [7:0]       s_w, e_w, far_w, ph0, step, step_c, loc_w, loc_c;
    logic                    seen0, fwd_step, seen_step, eoc_step;

    assign b       = loop_bounds(cfg);
    assign mode    = (cfg.play_mode > MODE_RANDOM) ? MODE_RANDOM : cfg.play_mode;
    assign s_w     = $signed({2'b00, b.lo});
    assign e_w     = $signed({2'b00, b.hi});
    assign far_sum = {1'b0, b.lo} + b.len;
    assign far_w   = (far_sum > {1'b0, LAST_COLUMN}) ? $signed({2'b00, LAST_COLUMN})
                                                     : $signed({1'b0, far_sum});
    assign prod    = item.random_fraction * b.len;
    assign off     = prod[FRAC_W+LEN_W-1:FRAC_W];
    assign loc_w   = $signed({2'b00, item.column});
    assign loc_c   = (loc_w < s_w) ? s_w : ((loc_w > e_w) ? e_w : loc_w);

    always_comb
    begin
        if (armed_reg)
            ph0 = (mode == MODE_BACKWARD || mode == MODE_PINGPONG_ALT) ? s_w : far_w;
        else
            ph0 = $signed({2'b00, playhead_reg});
        seen0     = armed_reg ? 1'b0 : seen_reg;
        step      = ph0;
        fwd_step  = fwd_reg;
        seen_step = seen0;
        eoc_step  = 1'b0;
        case (mode)
            MODE_FORWARD:
            begin
                step     = ph0 + 8'sd1;
                fwd_step = 1'b1;
                if (step > e_w)
                begin
                    step      = s_w;
                    eoc_step  = seen0;
                    seen_step = 1'b1;
                end
            end
            MODE_BACKWARD:
            begin
                step     = (ph0 > s_w) ? ph0 - 8'sd1 : e_w;
                fwd_step = 1'b0;
                if (step == e_w)
                begin
                    eoc_step  = seen0;
                    seen_step = 1'b1;
                end
            end
            MODE_PINGPONG, MODE_PINGPONG_ALT:
            begin
                if (fwd_reg)
                begin
                    if (ph0 < e_w)
                        step = ph0 + 8'sd1;
                    else
                    begin
                        step      = ph0 - 8'sd1;
                        fwd_step  = 1'b0;
                        eoc_step  = seen0;
                        seen_step = 1'b1;
                    end
                end
                else
                begin
                    if (ph0 > s_w)
                        step = ph0 - 8'sd1;
                    else
                    begin
                        step      = ph0 + 8'sd1;
                        fwd_step  = 1'b1;
                        eoc_step  = seen0;
                        seen_step = 1'b1;
                    end
                end
            end
            default:
            begin
                step = s_w + $signed({1'b0, off});
            end
        endcase
        step_c = (step < s_w) ? s_w : ((step > e_w) ? e_w : step);
    end

    always_comb
    begin
        playhead_next = playhead_reg;
        armed_next    = armed_reg;
        fwd_next      = fwd_reg;
        seen_next     = seen_reg;
        eoc_next      = eoc_reg;
        if (update)
        begin
            eoc_next = 1'b0;
            case (item.op)
                OP_CLOCK:
                begin
                    playhead_next = step_c[COL_W-1:0];
                    armed_next    = 1'b0;
                    fwd_next      = fwd_step;
                    seen_next     = seen_step;
                    eoc_next      = eoc_step;
                end
                OP_ARM:
                begin
                    armed_next = 1'b1;
                end
                OP_LOCATE:
                begin
                    playhead_next = loc_c[COL_W-1:0];
                    armed_next    = 1'b0;
                    seen_next     = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            playhead_reg <= '0;
            armed_reg    <= 1'b1;
            fwd_reg      <= 1'b1;
            seen_reg     <= 1'b0;
            eoc_reg      <= 1'b0;
        end
        else
        begin
            playhead_reg <= playhead_next;
            armed_reg    <= armed_next;
            fwd_reg      <= fwd_next;
            seen_reg     <= seen_next;
            eoc_reg      <= eoc_next;
        end
    end

    assign motion.pos = armed_reg ? b.lo : playhead_reg;
    assign motion.eoc = eoc_reg;

endmodule

FILE: rtl/core/grid_step_sequencer_playhead_top.sv
// Top level of the grid step sequencer playhead: config, sequencer, grid RAM.
// Depends on gsp_pkg, gsp_ram, gsp_divider, gsp_motion and the macros header.
//
// Usage:
//   item channel (item_valid / item_stall / item): one operation per beat:
//   clock, arm reset, clear grid, set cell or locate.
//   result channel (result_valid / result_stall / result): one beat per item,
//   giving the shown column, its gates, the gate count, the end-of-cycle flag
//   and the scaled position.
//   cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data): register writes,
//   always ready; write only while no item is in flight.
// Sequence: a taken item passes through the fetch, divide and finish states
//   (set cell first adds a modify state, a read-modify-write of the grid
//   column). A new item is taken only back in idle, after the result is loaded;
//   the scaled-position divider gives 4 quotient bits per cycle over 16 bits.
// The result sits in an output register; the next item is taken while it
//   waits, and the sequencer holds in its final state while the receiver stalls
//   with a result still pending.
// Reset: config returns to start 0, length 64, forward, loop scaling; the grid
//   reads empty at once through per-column valid bits (no clearing pass);
//   the playhead is armed.
`timescale 1ns / 1ps
`include "grid_step_sequencer_playhead_top_macros.svh"

module grid_step_sequencer_playhead_top (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_stall,
    input  gsp_pkg::item_t         item,
    output logic                   result_valid,
    input  logic                   result_stall,
    output gsp_pkg::result_t       result,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  gsp_pkg::cfg_index_t    cfg_index,
    input  logic [gsp_pkg::LEN_W-1:0] cfg_data
);
    import gsp_pkg::*;

    state_t           state_reg, state_next;
    cfg_t             cfg_reg, cfg_next;
    item_t            item_reg, item_next;
    logic [COLUMNS-1:0] col_valid_reg, col_valid_next;
    logic             zero_reg, zero_next;
    result_t          result_reg, result_next;
    logic             result_valid_reg, result_valid_next;

    logic             accept, ram_we, div_start, load_result, out_free;
    logic [COL_W-1:0] raddr;
    logic [ROWS-1:0]  rdata, wdata, base_word, gates;
    motion_t          motion;
    div_status_t      div_status;
    logic [DIV_W-1:0] quotient, dividend;
    bounds_t          b;
    logic [COL_W-1:0] lo, hi, span;
    logic [COL_W:0]   diff;
    logic [SCALE_W-1:0] scaled;

    assign cfg_ready = 1'b1;
    assign out_free  = !result_valid_reg || !result_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                    state_next = (item.op == OP_SET_CELL) ? ST_MODIFY : ST_FETCH;
            end
            ST_MODIFY: state_next = ST_FETCH;
            ST_FETCH:  state_next = ST_DIVIDE;
            ST_DIVIDE:
            begin
                if (div_status.last)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        item_stall  = 1'b1;
        accept      = 1'b0;
        ram_we      = 1'b0;
        div_start   = 1'b0;
        load_result = 1'b0;
        raddr       = motion.pos;
        case (state_reg)
            ST_IDLE:
            begin
                item_stall = 1'b0;
                accept     = item_valid;
                raddr      = item.column;
            end
            ST_MODIFY: ram_we = 1'b1;
            ST_FETCH:  div_start = 1'b1;
            ST_FINISH: load_result = out_free;
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_START:  cfg_next.start_column   = cfg_data[COL_W-1:0];
                CFG_LENGTH: cfg_next.loop_length    = cfg_data;
                CFG_MODE:   cfg_next.play_mode      = cfg_data[2:0];
                CFG_SCALE:  cfg_next.absolute_scale = cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // grid column update
    assign base_word = col_valid_reg[item_reg.column] ? rdata : '0;
    always_comb
    begin
        wdata                = base_word;
        wdata[item_reg.row]  = item_reg.cell_value;
    end

    always_comb
    begin
        col_valid_next = col_valid_reg;
        if (accept && item.op == OP_CLEAR)
            col_valid_next = '0;
        else if (ram_we)
            col_valid_next[item_reg.column] = 1'b1;
    end

    assign item_next = accept ? item : item_reg;

    // scaling operands
    assign b        = loop_bounds(cfg_reg);
    assign lo       = cfg_reg.absolute_scale ? '0 : b.lo;
    assign hi       = cfg_reg.absolute_scale ? LAST_COLUMN : b.hi;
    assign span     = hi - lo;
    assign diff     = {1'b0, motion.pos} - {1'b0, lo};
    assign dividend = {diff[COL_W-1:0], SCALE_W'(0)} - DIV_W'(diff[COL_W-1:0]);
    assign zero_next = div_start ? ((span == '0) || diff[COL_W] || (diff == '0)) : zero_reg;

    assign gates  = col_valid_reg[motion.pos] ? rdata : '0;
    assign scaled = zero_reg ? '0
                  : ((quotient[DIV_W-1:SCALE_W] != '0) ? SCALE_MAX : quotient[SCALE_W-1:0]);

    always_comb
    begin
        result_next = result_reg;
        if (load_result)
        begin
            result_next.position        = motion.pos;
            result_next.column_gates    = gates;
            result_next.rows_on         = count_ones(gates);
            result_next.end_of_cycle    = motion.eoc;
            result_next.position_scaled = scaled;
        end
    end

    always_comb
    begin
        if (load_result)
            result_valid_next = 1'b1;
        else if (!result_stall)
            result_valid_next = 1'b0;
        else
            result_valid_next = result_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            cfg_reg          <= '{start_column: '0, loop_length: LEN_MAX,
                                  play_mode: MODE_FORWARD, absolute_scale: 1'b0};
            col_valid_reg    <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cfg_reg          <= cfg_next;
            col_valid_reg    <= col_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        zero_reg   <= zero_next;
        result_reg <= result_next;
    end

    gsp_ram #(
        .WIDTH(ROWS),
        .DEPTH(COLUMNS)
    ) u_grid (
        .clk   (clk),
        .we    (ram_we),
        .waddr (item_reg.column),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    gsp_motion u_motion (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .update (accept),
        .item   (item),
        .motion (motion)
    );

    gsp_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (span),
        .status   (div_status),
        .quotient (quotient)
    );

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `GSP_ASSERT_IMPLIES(a_load_from_finish, clk, rst_n, $rose(result_valid), $past(state_reg) == ST_FINISH)
    `GSP_ASSERT_IMPLIES(a_div_last_in_divide, clk, rst_n, div_status.last, state_reg == ST_DIVIDE)
    `GSP_ASSERT_NEXT(a_fetch_starts_div, clk, rst_n, state_reg == ST_FETCH, div_status.busy)

endmodule
